@@ rtl/lprd_pkg.sv @@
package lprd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned COUNT_W = 20;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [WORD_W-1:0] MAX_LEN_RESET = WORD_W'(32 << 20);
	localparam logic [COUNT_W-1:0] MAX_ARGS_RESET = COUNT_W'(200 * 1000);

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARGS = CFG_INDEX_W'(1);

	typedef enum logic [2:0] {
		PH_OUTER    = 3'd0,
		PH_COUNT    = 3'd1,
		PH_ARGLEN   = 3'd2,
		PH_ARGDATA  = 3'd3,
		PH_LEFTOVER = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_BYTE      = 3'd0,
		KIND_EMPTY_ARG = 3'd1,
		KIND_EMPTY_REQ = 3'd2,
		KIND_TOO_LONG  = 3'd3,
		KIND_TOO_MANY  = 3'd4,
		KIND_MALFORMED = 3'd5
	} kind_t;

endpackage

@@ rtl/length_prefixed_request_deframer.sv @@
// Length-prefixed request deframer.
// The input channel (in_valid, in_stall, rx_byte) takes one byte of the received
// stream per transaction. Each request is a 4-byte little-endian payload length,
// a 4-byte argument count, and per argument a 4-byte length and its bytes.
// The output channel (out_valid, out_stall and the result fields) carries at
// most one result per input byte: an argument byte, an empty-argument or
// empty-request marker, or an error code. Bytes are forwarded before any later
// error in the same request is known; after an error the block stays silent
// until reset.
// A byte taken into the input register passes through the whole parsing step, which is
// combinational, and its result is captured in the result register.
// Throughput is one byte per cycle while the receiver takes results.
// When the receiver stalls a pending result, the result holds and the input register
// takes one more byte if it was empty; in_stall is then high until the result is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle, which is not enforced.
// Reset (arst_n low) restores the limit registers to their defaults, returns
// the parser to the payload length field and clears the error condition.
module length_prefixed_request_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          kind,
	output logic [7:0]                          data_byte,
	output logic [lprd_pkg::COUNT_W-1:0]        arg_index,
	output logic                                last_of_arg,
	output logic                                end_of_request,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lprd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lprd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned W = lprd_pkg::WORD_W;
	localparam int unsigned CW = lprd_pkg::COUNT_W;

	logic [W-1:0] max_len_q;
	logic [CW-1:0] max_args_q;

	logic byte_valid_s1;
	logic [7:0] byte_s1;

	lprd_pkg::phase_t phase_q, phase_d;
	logic [1:0] wcount_q, wcount_d;
	logic [W-1:0] wshift_q, wshift_d;
	logic [W-1:0] payload_q, payload_d;
	logic [CW-1:0] args_q, args_d;
	logic [CW-1:0] cur_arg_q, cur_arg_d;
	logic [W-1:0] str_q, str_d;
	logic closed_q, closed_d;

	logic out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] data_q;
	logic [CW-1:0] index_q;
	logic last_q;
	logic end_q;

	logic emit;
	logic [2:0] kind_d;
	logic [7:0] data_d;
	logic [CW-1:0] index_d;
	logic last_d;
	logic end_d;

	logic adv;
	logic [W-1:0] word_new;
	logic word_done;
	logic [W-1:0] payload_dec;
	logic [W-1:0] data_payload;
	logic [W-1:0] data_str;
	logic [CW-1:0] args_dec;

	assign adv = !(out_valid_q && out_stall);
	assign in_stall = byte_valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign data_byte = data_q;
	assign arg_index = index_q;
	assign last_of_arg = last_q;
	assign end_of_request = end_q;

	assign word_new = {byte_s1, wshift_q[W-1:8]};
	assign word_done = (wcount_q == 2'd3);
	assign payload_dec = payload_q - W'(1);
	assign data_payload = (payload_q != '0) ? payload_dec : payload_q;
	assign data_str = (str_q != '0) ? (str_q - W'(1)) : str_q;
	assign args_dec = args_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lprd_pkg::MAX_LEN_RESET;
			max_args_q <= lprd_pkg::MAX_ARGS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lprd_pkg::REG_MAX_LEN) begin
				max_len_q <= cfg_data[W-1:0];
			end else if (cfg_index == lprd_pkg::REG_MAX_ARGS) begin
				max_args_q <= cfg_data[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			byte_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		phase_d = phase_q;
		wcount_d = wcount_q;
		wshift_d = wshift_q;
		payload_d = payload_q;
		args_d = args_q;
		cur_arg_d = cur_arg_q;
		str_d = str_q;
		closed_d = closed_q;
		emit = 1'b0;
		kind_d = lprd_pkg::KIND_BYTE;
		data_d = '0;
		index_d = '0;
		last_d = 1'b0;
		end_d = 1'b0;
		if (!closed_q) begin
			case (phase_q)
				lprd_pkg::PH_OUTER: begin
					wshift_d = word_new;
					wcount_d = wcount_q + 2'd1;
					if (word_done) begin
						if (word_new > max_len_q) begin
							closed_d = 1'b1;
							emit = 1'b1;
							kind_d = lprd_pkg::KIND_TOO_LONG;
						end else begin
							payload_d = word_new;
							phase_d = lprd_pkg::PH_COUNT;
						end
					end
				end
				lprd_pkg::PH_COUNT: begin
					if (payload_q == '0) begin
						closed_d = 1'b1;
						emit = 1'b1;
						kind_d = lprd_pkg::KIND_MALFORMED;
					end else begin
						payload_d = payload_dec;
						wshift_d = word_new;
						wcount_d = wcount_q + 2'd1;
						if (word_done) begin
							if (word_new > W'(max_args_q)) begin
								closed_d = 1'b1;
								emit = 1'b1;
								kind_d = lprd_pkg::KIND_TOO_MANY;
							end else begin
								args_d = word_new[CW-1:0];
								cur_arg_d = '0;
								if (word_new[CW-1:0] != '0) begin
									phase_d = lprd_pkg::PH_ARGLEN;
								end else if (payload_dec == '0) begin
									phase_d = lprd_pkg::PH_OUTER;
									emit = 1'b1;
									kind_d = lprd_pkg::KIND_EMPTY_REQ;
									end_d = 1'b1;
								end else begin
									phase_d = lprd_pkg::PH_LEFTOVER;
								end
							end
						end
					end
				end
				lprd_pkg::PH_ARGLEN: begin
					if (payload_q == '0) begin
						closed_d = 1'b1;
						emit = 1'b1;
						kind_d = lprd_pkg::KIND_MALFORMED;
					end else begin
						payload_d = payload_dec;
						wshift_d = word_new;
						wcount_d = wcount_q + 2'd1;
						if (word_done) begin
							if (word_new > payload_dec) begin
								closed_d = 1'b1;
								emit = 1'b1;
								kind_d = lprd_pkg::KIND_MALFORMED;
							end else if (word_new != '0) begin
								str_d = word_new;
								phase_d = lprd_pkg::PH_ARGDATA;
							end else begin
								str_d = word_new;
								emit = 1'b1;
								kind_d = lprd_pkg::KIND_EMPTY_ARG;
								index_d = cur_arg_q;
								last_d = 1'b1;
								args_d = args_dec;
								cur_arg_d = cur_arg_q + CW'(1);
								if (args_dec != '0) begin
									phase_d = lprd_pkg::PH_ARGLEN;
								end else if (payload_dec == '0) begin
									phase_d = lprd_pkg::PH_OUTER;
									end_d = 1'b1;
								end else begin
									phase_d = lprd_pkg::PH_LEFTOVER;
								end
							end
						end
					end
				end
				lprd_pkg::PH_ARGDATA: begin
					payload_d = data_payload;
					str_d = data_str;
					emit = 1'b1;
					kind_d = lprd_pkg::KIND_BYTE;
					data_d = byte_s1;
					index_d = cur_arg_q;
					if (data_str == '0) begin
						last_d = 1'b1;
						args_d = args_dec;
						cur_arg_d = cur_arg_q + CW'(1);
						if (args_dec != '0) begin
							phase_d = lprd_pkg::PH_ARGLEN;
						end else if (data_payload == '0) begin
							phase_d = lprd_pkg::PH_OUTER;
							end_d = 1'b1;
						end else begin
							phase_d = lprd_pkg::PH_LEFTOVER;
						end
					end
				end
				default: begin
					closed_d = 1'b1;
					emit = 1'b1;
					kind_d = lprd_pkg::KIND_MALFORMED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lprd_pkg::PH_OUTER;
			wcount_q <= '0;
			wshift_q <= '0;
			payload_q <= '0;
			args_q <= '0;
			cur_arg_q <= '0;
			str_q <= '0;
			closed_q <= 1'b0;
		end else if (adv && byte_valid_s1) begin
			phase_q <= phase_d;
			wcount_q <= wcount_d;
			wshift_q <= wshift_d;
			payload_q <= payload_d;
			args_q <= args_d;
			cur_arg_q <= cur_arg_d;
			str_q <= str_d;
			closed_q <= closed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= byte_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= kind_d;
			data_q <= data_d;
			index_q <= index_d;
			last_q <= last_d;
			end_q <= end_d;
		end
	end

`ifndef SYNTH
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("error condition cleared without reset");

	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == lprd_pkg::KIND_TOO_LONG
			|| kind_q == lprd_pkg::KIND_TOO_MANY
			|| kind_q == lprd_pkg::KIND_MALFORMED)
		|-> closed_q && !end_q && !last_q)
		else $error("error result without closing the parser");

	a_silent_closed: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q && !out_valid_q |=> !out_valid_q)
		else $error("result produced after an error");

	a_end_realigns: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && end_q
		|-> phase_q == lprd_pkg::PH_OUTER && wcount_q == 2'd0)
		else $error("request ended without returning to the length field");
`endif

endmodule

@@ tb/length_prefixed_request_deframer_tb.sv @@
`timescale 1ns / 1ps

typedef logic [lprd_pkg::WORD_W-1:0] word_t;
typedef logic [lprd_pkg::COUNT_W-1:0] count_t;
typedef logic [lprd_pkg::CFG_INDEX_W-1:0] cfg_index_t;

typedef struct packed {
	logic [2:0] kind;
	logic [7:0] data;
	count_t     arg_idx;
	logic       last;
	logic       eor;
} deframe_result_t;

class request_scoreboard;
	word_t              max_len;
	count_t             max_args;
	lprd_pkg::phase_t   phase;
	logic [1:0]         word_bytes;
	word_t              word_shift;
	word_t              payload_left;
	count_t             args_left;
	count_t             current_arg;
	word_t              string_left;
	bit                 closed;
	deframe_result_t    expected_results[$];
	int unsigned        mismatches;

	function new();
		max_len = lprd_pkg::MAX_LEN_RESET;
		max_args = lprd_pkg::MAX_ARGS_RESET;
		phase = lprd_pkg::PH_OUTER;
		word_bytes = '0;
		word_shift = '0;
		payload_left = '0;
		args_left = '0;
		current_arg = '0;
		string_left = '0;
		closed = 1'b0;
		mismatches = 0;
	endfunction

	function void write_limit(input cfg_index_t index, input logic [31:0] value);
		if (index == lprd_pkg::REG_MAX_LEN)
			max_len = value;
		else if (index == lprd_pkg::REG_MAX_ARGS)
			max_args = value[lprd_pkg::COUNT_W-1:0];
	endfunction

	function void add_result(input lprd_pkg::kind_t k, input logic [7:0] d,
			input count_t idx, input bit last, input bit eor);
		deframe_result_t r;
		r.kind = k;
		r.data = d;
		r.arg_idx = idx;
		r.last = last;
		r.eor = eor;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function void reject(input lprd_pkg::kind_t k);
		closed = 1'b1;
		add_result(k, 8'h00, '0, 1'b0, 1'b0);
	endfunction

	// Little-endian word assembly; true once the fourth byte is in.
	function bit shift_in(input logic [7:0] b);
		word_shift = {b, word_shift[lprd_pkg::WORD_W-1:8]};
		word_bytes = word_bytes + 2'd1;
		return word_bytes == 2'd0;
	endfunction

	function bit close_arg();
		args_left = args_left - count_t'(1);
		current_arg = current_arg + count_t'(1);
		if (args_left != 0) begin
			phase = lprd_pkg::PH_ARGLEN;
			return 1'b0;
		end
		if (payload_left == 0) begin
			phase = lprd_pkg::PH_OUTER;
			return 1'b1;
		end
		phase = lprd_pkg::PH_LEFTOVER;
		return 1'b0;
	endfunction

	function void note_rx_byte(input logic [7:0] b);
		count_t idx;
		bit last;
		bit eor;
		if (closed)
			return;
		case (phase)
			lprd_pkg::PH_OUTER: begin
				if (shift_in(b)) begin
					if (word_shift > max_len) begin
						reject(lprd_pkg::KIND_TOO_LONG);
					end else begin
						payload_left = word_shift;
						phase = lprd_pkg::PH_COUNT;
					end
				end
			end
			lprd_pkg::PH_COUNT: begin
				if (payload_left == 0) begin
					reject(lprd_pkg::KIND_MALFORMED);
					return;
				end
				payload_left = payload_left - word_t'(1);
				if (!shift_in(b))
					return;
				if (word_shift > word_t'(max_args)) begin
					reject(lprd_pkg::KIND_TOO_MANY);
					return;
				end
				args_left = word_shift[lprd_pkg::COUNT_W-1:0];
				current_arg = '0;
				if (args_left != 0) begin
					phase = lprd_pkg::PH_ARGLEN;
				end else if (payload_left == 0) begin
					phase = lprd_pkg::PH_OUTER;
					add_result(lprd_pkg::KIND_EMPTY_REQ, 8'h00, '0, 1'b0, 1'b1);
				end else begin
					phase = lprd_pkg::PH_LEFTOVER;
				end
			end
			lprd_pkg::PH_ARGLEN: begin
				if (payload_left == 0) begin
					reject(lprd_pkg::KIND_MALFORMED);
					return;
				end
				payload_left = payload_left - word_t'(1);
				if (!shift_in(b))
					return;
				if (word_shift > payload_left) begin
					reject(lprd_pkg::KIND_MALFORMED);
					return;
				end
				string_left = word_shift;
				if (string_left != 0) begin
					phase = lprd_pkg::PH_ARGDATA;
				end else begin
					idx = current_arg;
					eor = close_arg();
					add_result(lprd_pkg::KIND_EMPTY_ARG, 8'h00, idx, 1'b1, eor);
				end
			end
			lprd_pkg::PH_ARGDATA: begin
				if (payload_left != 0)
					payload_left = payload_left - word_t'(1);
				if (string_left != 0)
					string_left = string_left - word_t'(1);
				idx = current_arg;
				last = (string_left == 0);
				eor = last ? close_arg() : 1'b0;
				add_result(lprd_pkg::KIND_BYTE, b, idx, last, eor);
			end
			default: begin
				reject(lprd_pkg::KIND_MALFORMED);
			end
		endcase
	endfunction

	function void check_result(input deframe_result_t got);
		deframe_result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result kind=%0d data=%02h arg=%0d last=%0b end=%0b",
					$time, got.kind, got.data, got.arg_idx, got.last, got.eor);
			return;
		end
		want = expected_results.pop_front();
		if (got.kind !== want.kind || got.data !== want.data || got.arg_idx !== want.arg_idx ||
				got.last !== want.last || got.eor !== want.eor) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t: expected kind=%0d data=%02h arg=%0d last=%0b end=%0b, ",
					"got kind=%0d data=%02h arg=%0d last=%0b end=%0b"}, $time,
					want.kind, want.data, want.arg_idx, want.last, want.eor,
					got.kind, got.data, got.arg_idx, got.last, got.eor);
		end
	endfunction

	function void check_drained();
		if (expected_results.size() != 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0d expected results never arrived", expected_results.size());
		end
	endfunction
endclass

module length_prefixed_request_deframer_tb;

	localparam cfg_index_t REG_SPARE_LO = cfg_index_t'(2);
	localparam cfg_index_t REG_SPARE_HI = cfg_index_t'(3);
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef enum int unsigned {
		FAULT_TOO_LONG,
		FAULT_TOO_MANY,
		FAULT_ARG_PAST_END,
		FAULT_EARLY_END,
		FAULT_LEFTOVER
	} fault_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             rx_byte = 8'h00;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [2:0]             kind;
	logic [7:0]             data_byte;
	count_t                 arg_index;
	logic                   last_of_arg;
	logic                   end_of_request;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	cfg_index_t             cfg_index = '0;
	logic [lprd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	request_scoreboard board;
	int unsigned       send_idle_pct = 32;
	int unsigned       recv_idle_pct = 45;
	int unsigned       bytes_sent = 0;
	int unsigned       quiet_cycles = 0;
	logic [7:0]        frame_bytes[$];
	int unsigned       arg_lengths[$];

	length_prefixed_request_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.arg_index      (arg_index),
		.last_of_arg    (last_of_arg),
		.end_of_request (end_of_request),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			board.check_result({kind, data_byte, arg_index, last_of_arg, end_of_request});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		board.note_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic write_limit(input cfg_index_t index, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		board.write_limit(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Bytes that cause no result may still be in flight once the queue empties.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			frame_bytes.insert(frame_bytes.size(), w[8*i +: 8]);
	endtask

	task automatic push_random_bytes(input int unsigned n);
		repeat (n) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i]);
		frame_bytes.delete();
	endtask

	task automatic send_request();
		logic [31:0] payload;
		payload = 32'd4;
		foreach (arg_lengths[i])
			payload += 32'd4 + arg_lengths[i];
		push_word(payload);
		push_word(arg_lengths.size());
		foreach (arg_lengths[i]) begin
			push_word(arg_lengths[i]);
			push_random_bytes(arg_lengths[i]);
		end
		arg_lengths.delete();
		send_frame();
	endtask

	task automatic send_random_request(input int unsigned count_cap, input int unsigned len_cap);
		int unsigned n;
		n = $urandom_range(count_cap);
		repeat (n) arg_lengths.insert(arg_lengths.size(),
			($urandom_range(4) == 0) ? 0 : $urandom_range(len_cap, 1));
		send_request();
	endtask

	initial begin
		fault_t fault;
		int unsigned len;
		int unsigned extra;
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request();
		push_word(32'd14);
		push_word(32'd2);
		push_word(32'd0);
		push_word(32'd2);
		frame_bytes.insert(frame_bytes.size(), 8'h00);
		frame_bytes.insert(frame_bytes.size(), 8'hFF);
		send_frame();
		drain();

		write_limit(lprd_pkg::REG_MAX_LEN, 32'hFFFF_FFFF);
		write_limit(lprd_pkg::REG_MAX_ARGS, {12'($urandom_range(4095)), 20'hFFFFF});
		while (bytes_sent < 300)
			send_random_request(6, 12);
		drain();

		send_idle_pct = 45;
		recv_idle_pct = 32;
		write_limit(lprd_pkg::REG_MAX_LEN, $urandom_range(200, 104));
		write_limit(lprd_pkg::REG_MAX_ARGS, $urandom_range(6, 2));
		arg_lengths.insert(arg_lengths.size(), board.max_len - 8);
		send_request();
		repeat (board.max_args) arg_lengths.insert(arg_lengths.size(), $urandom_range(3));
		send_request();
		while (bytes_sent < 560)
			send_random_request(board.max_args, 12);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(REG_SPARE_LO, $urandom);
		write_limit(REG_SPARE_HI, $urandom);
		write_limit(lprd_pkg::REG_MAX_LEN, 32'd4);
		write_limit(lprd_pkg::REG_MAX_ARGS, {12'($urandom_range(4095)), 20'd0});
		repeat (6) send_request();
		drain();

		write_limit(lprd_pkg::REG_MAX_LEN, $urandom_range(65535, 4096));
		write_limit(lprd_pkg::REG_MAX_ARGS,
			{12'($urandom_range(4095)), 20'($urandom_range(64, 8))});
		while (bytes_sent < 800)
			send_random_request(8, 40);
		drain();

		// Any error closes the block until reset, so the run ends with exactly one.
		fault = fault_t'($urandom_range(4));
		len = $urandom_range(10);
		extra = $urandom_range(5, 1);
		case (fault)
			FAULT_TOO_LONG: begin
				if ($urandom_range(1))
					write_limit(lprd_pkg::REG_MAX_LEN, 32'd0);
				push_word(board.max_len + $urandom_range(1000, 1));
				push_word(32'd0);
			end
			FAULT_TOO_MANY: begin
				push_word(32'd8);
				push_word(board.max_args + $urandom_range(1000, 1));
				push_word(32'd0);
			end
			FAULT_ARG_PAST_END: begin
				push_word(32'd8 + len);
				push_word(32'd1);
				push_word(len + 1);
				push_random_bytes(len);
			end
			FAULT_EARLY_END: begin
				if ($urandom_range(1)) begin
					push_word($urandom_range(3));
					push_word(32'd0);
				end else begin
					push_word(32'd8 + len);
					push_word(32'd2);
					push_word(len);
					push_random_bytes(len);
					push_word(32'd0);
				end
			end
			default: begin
				if ($urandom_range(1)) begin
					push_word(32'd4 + extra);
					push_word(32'd0);
				end else begin
					push_word(32'd8 + len + extra);
					push_word(32'd1);
					push_word(len);
					push_random_bytes(len);
				end
				push_random_bytes(extra);
			end
		endcase
		push_random_bytes(16);
		send_frame();
		drain();

		board.check_drained();
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
